@@ rtl/tpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_pkg
// Types and constants shared by the tile pixel generator.
// ----------------------------------------------------------------------------
package tpg_pkg;

  localparam int FONT_WORDS_DEF = 16384;
  localparam int FONT_ADDR_W    = 14;
  localparam int WORD_W         = 16;
  localparam int TILE_W         = 11;
  localparam int PAL_W          = 8;
  localparam int COORD_W        = 9;
  localparam int COLOUR_W       = 2;
  localparam int IDX_W          = 3;   // row / column inside a tile

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_DRAW  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_REMAIN,
    ST_ROWADDR,
    ST_FETCH,
    ST_RMW,
    ST_READOUT,
    ST_PIXEL
  } state_e;

endpackage

@@ rtl/tile_pixel_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_pixel_generator
// 2bpp 8x8 tile renderer with a masked-write font store.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken on a clock edge with start_i high and
//   busy_o low. cmd 0 writes a font word (font_data | old & ~byte_mask),
//   cmd 1 reads one word, cmd 2 draws one tile, cmd 3 is dropped.
//   Result channel: result_valid_o marks a result for one cycle; the
//   receiver cannot stall, so results are never held.
//   Every store address is reduced modulo FONT_WORDS: a reciprocal
//   multiply gives the quotient, then the same multiplier and the
//   compare/subtract unit take quotient * FONT_WORDS off the address.
//   Write: reduce, fetch, then read-modify-write; no result.
//   Read: reduce, fetch, then one result (last_o set) in READOUT.
//   Draw: reduce, row address and fetch, then 64 pixels back to back,
//   row by row. The next row is fetched from the single memory read
//   port during the last pixel of the current row, and its address is
//   computed by the same compare/subtract unit.
//   Reset returns the sequencer to idle; font store contents are undefined
//   until written.
// ----------------------------------------------------------------------------
module tile_pixel_generator
  import tpg_pkg::*;
#(
  parameter int FONT_WORDS = FONT_WORDS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [1:0]             cmd_i,
  input  logic [FONT_ADDR_W-1:0] font_addr_i,
  input  logic [WORD_W-1:0]      font_data_i,
  input  logic [WORD_W-1:0]      byte_mask_i,
  input  logic [TILE_W-1:0]      tile_code_i,
  input  logic                   flip_x_i,
  input  logic                   flip_y_i,
  input  logic                   transparent_i,
  input  logic [PAL_W-1:0]       palette_i,
  input  logic [COORD_W-1:0]     origin_x_i,
  input  logic [COORD_W-1:0]     origin_y_i,
  output logic                   result_valid_o,
  output logic [COORD_W-1:0]     pixel_x_o,
  output logic [COORD_W-1:0]     pixel_y_o,
  output logic [COLOUR_W-1:0]    colour_o,
  output logic                   write_enable_o,
  output logic [WORD_W-1:0]      read_word_o,
  output logic                   last_o
);

  localparam int AW       = $clog2(FONT_WORDS);
  localparam int NW       = $clog2(FONT_WORDS + 1);
  localparam int CMP_W    = (FONT_ADDR_W + 1 > NW) ? FONT_ADDR_W + 1 : NW;
  // (a * RECIP) >> RECIP_SH is floor(a / FONT_WORDS) for every 14-bit a
  localparam int RECIP_SH = FONT_ADDR_W + AW;
  localparam int RECIP_W  = FONT_ADDR_W + 2;
  localparam longint RECIP_L = ((longint'(1) << RECIP_SH) + longint'(FONT_WORDS) - 1) /
                               longint'(FONT_WORDS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int MUL_B_W  = (RECIP_W > NW) ? RECIP_W : NW;
  localparam int MUL_W    = FONT_ADDR_W + MUL_B_W;
  localparam logic [IDX_W-1:0]  IDX_MAX  = '1;

  state_e state_q, state_d;

  cmd_e                   cmd_q;
  logic [WORD_W-1:0]      data_q;
  logic [WORD_W-1:0]      mask_q;
  logic                   fx_q, fy_q, tr_q;
  logic [PAL_W-1:0]       pal_q;
  logic [COORD_W-1:0]     ox_q, oy_q;

  logic [FONT_ADDR_W-1:0] acc_q;
  logic [FONT_ADDR_W-1:0] quo_q;
  logic [AW-1:0]          addr_q;
  logic [IDX_W-1:0]       row_q, col_q;
  logic [WORD_W-1:0]      rdata_q;

  logic [WORD_W-1:0]      font_mem_q [FONT_WORDS];

  logic                   accept;
  logic                   cmd_valid;
  logic                   mem_re, mem_we, strobe;
  logic [WORD_W-1:0]      wdata;

  // shared multiplier and compare/subtract unit
  logic [FONT_ADDR_W-1:0] mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [MUL_W-1:0]       mul_p;
  logic [CMP_W-1:0]       cmp_a, cmp_b, cmp_res;
  logic                   cmp_ge;
  logic [IDX_W-1:0]       src_row, src_idx;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign cmd_valid = (cmd_i == CMD_WRITE) || (cmd_i == CMD_READ) || (cmd_i == CMD_DRAW);

  assign src_row = (state_q == ST_PIXEL) ? row_q + IDX_W'(1) : row_q;
  assign src_idx = fy_q ? ~src_row : src_row;

  always_comb begin
    if (state_q == ST_REDUCE) begin
      mul_a = acc_q;
      mul_b = MUL_B_W'(RECIP);
    end else begin
      mul_a = quo_q;
      mul_b = MUL_B_W'(FONT_WORDS);
    end
    mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  always_comb begin
    if (state_q == ST_REMAIN) begin
      // quotient * FONT_WORDS never exceeds the address
      cmp_a = CMP_W'(acc_q);
      cmp_b = CMP_W'(mul_p);
    end else begin
      // base is already below FONT_WORDS, so one subtract wraps the row address
      cmp_a = CMP_W'(acc_q) + CMP_W'(src_idx);
      cmp_b = CMP_W'(FONT_WORDS);
    end
    cmp_ge  = (cmp_a >= cmp_b);
    cmp_res = cmp_ge ? cmp_a - cmp_b : cmp_a;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && cmd_valid) state_d = ST_REDUCE;
      end
      ST_REDUCE: state_d = ST_REMAIN;
      ST_REMAIN: begin
        state_d = (cmd_q == CMD_DRAW) ? ST_ROWADDR : ST_FETCH;
      end
      ST_ROWADDR: state_d = ST_FETCH;
      ST_FETCH: begin
        case (cmd_q)
          CMD_WRITE: state_d = ST_RMW;
          CMD_READ:  state_d = ST_READOUT;
          default:   state_d = ST_PIXEL;
        endcase
      end
      ST_RMW:     state_d = ST_IDLE;
      ST_READOUT: state_d = ST_IDLE;
      ST_PIXEL: begin
        if (col_q == IDX_MAX && row_q == IDX_MAX) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_re = 1'b0;
    mem_we = 1'b0;
    strobe = 1'b0;
    case (state_q)
      ST_FETCH:   mem_re = 1'b1;
      ST_RMW:     mem_we = 1'b1;
      ST_READOUT: strobe = 1'b1;
      ST_PIXEL: begin
        strobe = 1'b1;
        mem_re = (col_q == IDX_MAX) && (row_q != IDX_MAX);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  assign wdata = data_q | (rdata_q & ~mask_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          row_q  <= '0;
          col_q  <= '0;
        end
        ST_PIXEL: begin
          col_q <= col_q + IDX_W'(1);
          if (col_q == IDX_MAX) row_q <= row_q + IDX_W'(1);
        end
        default: begin
          col_q <= col_q;
        end
      endcase
    end
  end

  // item fields and address datapath
  always_ff @(posedge clk_i) begin
    if (accept && cmd_valid) begin
      cmd_q  <= cmd_e'(cmd_i);
      data_q <= font_data_i;
      mask_q <= byte_mask_i;
      fx_q   <= flip_x_i;
      fy_q   <= flip_y_i;
      tr_q   <= transparent_i;
      pal_q  <= palette_i;
      ox_q   <= origin_x_i;
      oy_q   <= origin_y_i;
      acc_q  <= (cmd_i == CMD_DRAW) ? {tile_code_i, {IDX_W{1'b0}}} : font_addr_i;
    end else if (state_q == ST_REDUCE) begin
      quo_q <= FONT_ADDR_W'(mul_p >> RECIP_SH);
    end else if (state_q == ST_REMAIN) begin
      acc_q  <= FONT_ADDR_W'(cmp_res);
      addr_q <= AW'(cmp_res);
    end else if (state_q == ST_ROWADDR ||
                 (state_q == ST_PIXEL && col_q == '0 && row_q != IDX_MAX)) begin
      addr_q <= AW'(cmp_res);
    end
  end

  // font store, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) font_mem_q[addr_q] <= wdata;
    if (mem_re) rdata_q <= font_mem_q[addr_q];
  end

  // pixel decode
  logic [IDX_W-1:0]    pix_idx;
  logic [1:0]          pix_dat;
  logic [COLOUR_W-1:0] pix_col;
  logic                is_pixel;

  assign is_pixel = (state_q == ST_PIXEL);
  assign pix_idx  = fx_q ? ~col_q : col_q;
  assign pix_dat  = rdata_q[{pix_idx, 1'b0} +: 2];
  assign pix_col  = (pix_dat == 2'd0) ? '0 : pal_q[{pix_dat, 1'b0} +: COLOUR_W];

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = strobe;
  assign pixel_x_o      = is_pixel ? ox_q + COORD_W'(col_q) : '0;
  assign pixel_y_o      = is_pixel ? oy_q + COORD_W'(row_q) : '0;
  assign colour_o       = is_pixel ? pix_col : '0;
  assign write_enable_o = is_pixel && (!tr_q || pix_col != '0);
  assign read_word_o    = (state_q == ST_READOUT) ? rdata_q : '0;
  assign last_o         = (state_q == ST_READOUT) ||
                          (is_pixel && col_q == IDX_MAX && row_q == IDX_MAX);

`ifndef SYNTHESIS
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe while idle");

  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o)
    else $error("last flag without result");

  a_row_addr_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROWADDR) |=> (int'(addr_q) < FONT_WORDS))
    else $error("row address not reduced below store depth");

  a_accept_starts_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_valid) |=> (state_q == ST_REDUCE))
    else $error("accepted item did not start address reduction");

  a_fetch_before_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIXEL && col_q == '0) |-> $past(mem_re))
    else $error("row emitted without a fetch");
`endif

endmodule

@@ test/tb_tile_pixel_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_pixel_generator
// Self-checking bench for the 2bpp 8x8 tile pixel generator.
// ----------------------------------------------------------------------------
// A queue of command items (font writes, font reads, tile draws, dropped
// codes) is built up front. A negedge driver feeds it to the block with
// random sender gaps, and a posedge monitor keeps a shadow font store,
// predicts every pixel and read word at acceptance and compares each strobed
// result with the oldest prediction. Only font words that have been written
// are ever read or drawn, and the first write to a word replaces it whole.
// ----------------------------------------------------------------------------
module tb_tile_pixel_generator;
  import tpg_pkg::*;

  localparam int          CLK_PERIOD   = 4;
  localparam int          RESET_CYCLES = 11;
  localparam int          TB_WORDS     = FONT_WORDS_DEF;
  localparam int          RAND_ITEMS   = 220;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [FONT_ADDR_W-1:0] font_addr;
    logic [WORD_W-1:0]      font_data;
    logic [WORD_W-1:0]      byte_mask;
    logic [TILE_W-1:0]      tile_code;
    logic                   flip_x;
    logic                   flip_y;
    logic                   transparent;
    logic [PAL_W-1:0]       palette;
    logic [COORD_W-1:0]     origin_x;
    logic [COORD_W-1:0]     origin_y;
  } cmd_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [COLOUR_W-1:0] colour;
    logic                we;
    logic [WORD_W-1:0]   word;
    logic                last;
  } pixel_out_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [1:0]             cmd_i;
  logic [FONT_ADDR_W-1:0] font_addr_i;
  logic [WORD_W-1:0]      font_data_i;
  logic [WORD_W-1:0]      byte_mask_i;
  logic [TILE_W-1:0]      tile_code_i;
  logic                   flip_x_i;
  logic                   flip_y_i;
  logic                   transparent_i;
  logic [PAL_W-1:0]       palette_i;
  logic [COORD_W-1:0]     origin_x_i;
  logic [COORD_W-1:0]     origin_y_i;
  logic                   result_valid_o;
  logic [COORD_W-1:0]     pixel_x_o;
  logic [COORD_W-1:0]     pixel_y_o;
  logic [COLOUR_W-1:0]    colour_o;
  logic                   write_enable_o;
  logic [WORD_W-1:0]      read_word_o;
  logic                   last_o;

  cmd_item_t   cmd_q[$];
  pixel_out_t  render_q[$];
  cmd_item_t   cur_item;
  pixel_out_t  oldest;
  logic [WORD_W-1:0] font_shadow [TB_WORDS];
  bit          written_map [TB_WORDS];
  int          written_list[$];
  int          filled_tiles[$];
  int          error_cnt    = 0;
  int          accepted_cnt = 0;
  int          total_items  = 0;
  int          noise_cnt    = 0;
  int          gap_left     = 0;
  int          idle_pct;
  bit          item_taken   = 1'b0;

  tile_pixel_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .font_addr_i    (font_addr_i),
    .font_data_i    (font_data_i),
    .byte_mask_i    (byte_mask_i),
    .tile_code_i    (tile_code_i),
    .flip_x_i       (flip_x_i),
    .flip_y_i       (flip_y_i),
    .transparent_i  (transparent_i),
    .palette_i      (palette_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .result_valid_o (result_valid_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .colour_o       (colour_o),
    .write_enable_o (write_enable_o),
    .read_word_o    (read_word_o),
    .last_o         (last_o)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  task automatic render_item(input cmd_item_t it);
    int                  a;
    int                  src;
    int                  pb;
    int                  pv;
    logic [WORD_W-1:0]   word;
    pixel_out_t          res;
    case (it.cmd)
      CMD_WRITE: begin
        a = int'(it.font_addr) % TB_WORDS;
        font_shadow[a] = it.font_data | (font_shadow[a] & ~it.byte_mask);
      end
      CMD_READ: begin
        res      = '0;
        res.word = font_shadow[int'(it.font_addr) % TB_WORDS];
        res.last = 1'b1;
        render_q.push_back(res);
      end
      CMD_DRAW: begin
        for (int row = 0; row < 8; row++) begin
          src  = it.flip_y ? 7 - row : row;
          word = font_shadow[(int'(it.tile_code) * 8 + src) % TB_WORDS];
          for (int col = 0; col < 8; col++) begin
            pb         = it.flip_x ? 7 - col : col;
            pv         = int'(word[2*pb +: 2]);
            res        = '0;
            res.px     = COORD_W'(int'(it.origin_x) + col);
            res.py     = COORD_W'(int'(it.origin_y) + row);
            res.colour = (pv == 0) ? '0 : it.palette[2*pv +: 2];
            res.we     = !it.transparent || (res.colour != '0);
            res.last   = (row == 7) && (col == 7);
            render_q.push_back(res);
          end
        end
      end
      default: ;  // dropped code, nothing happens
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_cnt++;
    end
  endtask

  // ------------------------------------------------------- stimulus builders
  function automatic cmd_item_t rand_item(input logic [1:0] cmd);
    cmd_item_t    it;
    logic [127:0] raw;
    raw            = {$urandom, $urandom, $urandom, $urandom};
    it             = raw[$bits(cmd_item_t)-1:0];
    it.cmd         = cmd;
    return it;
  endfunction

  // First write to a word replaces it whole so no undefined bits survive.
  task automatic push_write(input int addr, input logic [15:0] data,
                            input logic [15:0] mask);
    cmd_item_t it;
    it           = rand_item(CMD_WRITE);
    it.font_addr = FONT_ADDR_W'(addr);
    it.font_data = data;
    it.byte_mask = written_map[addr] ? mask : 16'hffff;
    if (!written_map[addr]) begin
      written_map[addr] = 1'b1;
      written_list.push_back(addr);
    end
    cmd_q.push_back(it);
  endtask

  task automatic push_read(input int addr);
    cmd_item_t it;
    it           = rand_item(CMD_READ);
    it.font_addr = FONT_ADDR_W'(addr);
    cmd_q.push_back(it);
  endtask

  task automatic push_draw(input int tile, input logic fx, input logic fy,
                           input logic tr, input logic [7:0] pal,
                           input logic [8:0] ox, input logic [8:0] oy);
    cmd_item_t it;
    it             = rand_item(CMD_DRAW);
    it.tile_code   = TILE_W'(tile);
    it.flip_x      = fx;
    it.flip_y      = fy;
    it.transparent = tr;
    it.palette     = pal;
    it.origin_x    = ox;
    it.origin_y    = oy;
    cmd_q.push_back(it);
  endtask

  task automatic push_noise();
    cmd_q.push_back(rand_item(CMD_UNUSED));
    noise_cnt++;
  endtask

  task automatic fill_tile(input int tile);
    for (int r = 0; r < 8; r++) push_write(tile * 8 + r, 16'($urandom), 16'($urandom));
    filled_tiles.push_back(tile);
  endtask

  function automatic logic [8:0] rand_origin();
    return ($urandom_range(3) == 0) ? 9'($urandom_range(504, 511)) : 9'($urandom);
  endfunction

  task automatic random_draw(input int tile);
    push_draw(tile, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
              rand_origin(), rand_origin());
  endtask

  // ------------------------------------------------------------ build items
  initial begin
    logic [15:0] rows [8];
    int          pick;
    int          tile;
    rows = '{16'h0000, 16'hffff, 16'h1be4, 16'he41b,
             16'h5555, 16'haaaa, 16'h3c3c, 16'hc3c3};

    rst_ni        = 1'b0;
    start_i       = 1'b0;
    cmd_i         = CMD_WRITE;
    font_addr_i   = '0;
    font_data_i   = '0;
    byte_mask_i   = '0;
    tile_code_i   = '0;
    flip_x_i      = 1'b0;
    flip_y_i      = 1'b0;
    transparent_i = 1'b0;
    palette_i     = '0;
    origin_x_i    = '0;
    origin_y_i    = '0;

    // directed: every pixel value, all flips, palette extremes, wrap corners
    for (int r = 0; r < 8; r++) push_write(r, rows[r], 16'hffff);
    filled_tiles.push_back(0);
    push_draw(0, 1'b0, 1'b0, 1'b0, 8'he4, 9'd0,   9'd0);
    push_draw(0, 1'b1, 1'b0, 1'b1, 8'h00, 9'd511, 9'd511);
    push_draw(0, 1'b0, 1'b1, 1'b1, 8'hff, 9'd504, 9'd300);
    push_draw(0, 1'b1, 1'b1, 1'b0, 8'h1b, 9'd507, 9'd509);
    push_write(0, 16'h0000, 16'h0000);   // empty mask keeps the old word
    push_write(2, 16'h0001, 16'hff00);   // data ORs into the kept low byte
    push_read(0);
    push_read(2);
    push_write(TB_WORDS - 1, 16'hffff, 16'hffff);
    push_write(TB_WORDS - 1, 16'h0000, 16'h00ff);
    push_read(TB_WORDS - 1);
    push_noise();
    push_draw(0, 1'b0, 1'b0, 1'b1, 8'he4, 9'd100, 9'd37);

    // random: fill-then-draw sequences, redraws, reads, rewrites, stray writes, noise
    while (cmd_q.size() - noise_cnt < RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        case ($urandom_range(7))
          0:       tile = 0;
          1:       tile = 2047;
          default: tile = $urandom_range(2047);
        endcase
        fill_tile(tile);
        if ($urandom_range(2) == 0)
          push_write(tile * 8 + $urandom_range(7), 16'($urandom), 16'($urandom));
        random_draw(tile);
      end else if (pick < 60) begin
        random_draw(filled_tiles[$urandom_range(filled_tiles.size() - 1)]);
      end else if (pick < 75) begin
        push_read(written_list[$urandom_range(written_list.size() - 1)]);
      end else if (pick < 82) begin
        push_write(written_list[$urandom_range(written_list.size() - 1)],
                   16'($urandom), 16'($urandom));
      end else if (pick < 92) begin
        push_write($urandom_range(TB_WORDS - 1), 16'($urandom), 16'($urandom));
      end else begin
        push_noise();
      end
    end
    total_items = cmd_q.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || start_i || render_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0 && render_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t ns: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // ------------------------------------------------------------------ driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (item_taken) accepted_cnt++;
      if (!start_i || item_taken) begin
        item_taken = 1'b0;
        if (accepted_cnt < total_items / 3) begin
          idle_pct = 19;
        end else if (accepted_cnt < 2 * total_items / 3) begin
          idle_pct = 66;
        end else begin
          idle_pct = 0;
        end
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (cmd_q.size() != 0 && $urandom_range(99) < idle_pct) begin
          gap_left = $urandom_range(11);
          start_i  <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur_item       = cmd_q.pop_front();
          cmd_i         <= cur_item.cmd;
          font_addr_i   <= cur_item.font_addr;
          font_data_i   <= cur_item.font_data;
          byte_mask_i   <= cur_item.byte_mask;
          tile_code_i   <= cur_item.tile_code;
          flip_x_i      <= cur_item.flip_x;
          flip_y_i      <= cur_item.flip_y;
          transparent_i <= cur_item.transparent;
          palette_i     <= cur_item.palette;
          origin_x_i    <= cur_item.origin_x;
          origin_y_i    <= cur_item.origin_y;
          start_i       <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        if (render_q.size() == 0) begin
          $display("%0t ns: result with nothing pending, expected none, actual x=%0h y=%0h",
                   $time, pixel_x_o, pixel_y_o);
          error_cnt++;
        end else begin
          oldest = render_q.pop_front();
          check_field("pixel_x",      16'(oldest.px),     16'(pixel_x_o));
          check_field("pixel_y",      16'(oldest.py),     16'(pixel_y_o));
          check_field("colour",       16'(oldest.colour), 16'(colour_o));
          check_field("write_enable", 16'(oldest.we),     16'(write_enable_o));
          check_field("read_word",    oldest.word,        read_word_o);
          check_field("last",         16'(oldest.last),   16'(last_o));
        end
      end
      // results of this item can only show up on later edges
      if (start_i && !busy_o) begin
        render_item(cur_item);
        item_taken = 1'b1;
      end
    end
  end

endmodule
